// File: sv/frd_pkg.sv
// frd_pkg: shared types, constants and helpers for the fraction reducer.
// Used by frd_divider, fraction_reducer_euclid and frd_checker.
// No dependencies.
package frd_pkg;

  // Data path width of numerator, denominator and all results
  localparam int DataWidth = 32;
  localparam int StatusW   = 2;

  // Result status codes
  localparam logic [StatusW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatusW-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [StatusW-1:0] STAT_OVERFLOW = 2'd2;

  // Input beat
  typedef struct packed {
    logic signed [DataWidth-1:0] num_in;
    logic signed [DataWidth-1:0] den_in;
  } frd_in_t;

  // Result beat
  typedef struct packed {
    logic signed [DataWidth-1:0] num_out;
    logic signed [DataWidth-1:0] den_out;
    logic        [StatusW-1:0]   status;
  } frd_out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOP,
    ST_REM,
    ST_DIVN,
    ST_WAITN,
    ST_DIVD,
    ST_WAITD
  } frd_state_e;

  // Two's complement negate, width kept
  function automatic logic [DataWidth-1:0] frd_neg(input logic [DataWidth-1:0] v);
    frd_neg = ~v + {{(DataWidth-1){1'b0}}, 1'b1};
  endfunction

  // Magnitude; the most negative value maps to 2^(W-1) as unsigned
  function automatic logic [DataWidth-1:0] frd_mag(input logic [DataWidth-1:0] v);
    frd_mag = v[DataWidth-1] ? frd_neg(v) : v;
  endfunction

endpackage

// File: sv/fraction_reducer_euclid.sv
// fraction_reducer_euclid: reduces a signed fraction to lowest terms.
// Depends on frd_pkg and frd_divider (the one shared divide unit).
//
//   channel   beat marker        payload                      flow control
//   input     start & !busy      in_i (num_in, den_in)        busy holds off
//   result    done_o, 1 cycle    result_o (num, den, status)  none, always taken
//
// Each division runs on the shared divider after a start state. An item
// takes one division per Euclid step (at most about 46 at 32 bits), then
// one each for the numerator and the denominator over the gcd.
// A zero denominator is answered in the cycle after the beat.
// Reset idles the sequencer and the divider; busy is low out of reset.
// Results cannot be stalled; a new beat may come in the cycle done_o is high.
module fraction_reducer_euclid
  import frd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  frd_in_t  in_i,
  output logic     busy,
  output logic     done_o,
  output frd_out_t result_o
);

  frd_state_e state_q, state_d;

  logic [DataWidth-1:0] num_q, num_d;
  logic [DataWidth-1:0] den_q, den_d;
  logic [DataWidth-1:0] a_q, a_d;
  logic [DataWidth-1:0] b_q, b_d;
  logic [DataWidth-1:0] qn_q, qn_d;
  logic                 ovf_q, ovf_d;
  frd_out_t             res_q, res_d;
  logic                 done_q, done_d;

  logic                 div_start;
  logic [DataWidth-1:0] div_dividend;
  logic [DataWidth-1:0] div_divisor;
  logic                 div_done;
  logic [DataWidth-1:0] div_quo;
  logic [DataWidth-1:0] div_rem;

  logic                 accept;
  logic                 q_neg;
  logic [DataWidth-1:0] q_signed;
  logic                 q_ovf;

  assign accept = start && (state_q == ST_IDLE);

  // Sign and overflow of the quotient of the part in flight over g
  always_comb begin
    q_neg    = ((state_q == ST_WAITN) ? num_q[DataWidth-1] : den_q[DataWidth-1])
               ^ b_q[DataWidth-1];
    q_signed = q_neg ? frd_neg(div_quo) : div_quo;
    // only MIN / -1 overflows: positive quotient of 2^(W-1)
    q_ovf    = ~q_neg & div_quo[DataWidth-1];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && (in_i.den_in != '0)) state_d = ST_LOOP;
      end
      ST_LOOP: begin
        state_d = (a_q == '0) ? ST_DIVN : ST_REM;
      end
      ST_REM: begin
        if (div_done) state_d = ST_LOOP;
      end
      ST_DIVN: begin
        state_d = ST_WAITN;
      end
      ST_WAITN: begin
        if (div_done) state_d = ST_DIVD;
      end
      ST_DIVD: begin
        state_d = ST_WAITD;
      end
      ST_WAITD: begin
        if (div_done) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Divider operand select and start
  always_comb begin
    div_start    = 1'b0;
    div_dividend = frd_mag(b_q);
    div_divisor  = frd_mag(a_q);
    case (state_q)
      ST_LOOP: begin
        div_start = (a_q != '0);
      end
      ST_DIVN: begin
        div_start    = 1'b1;
        div_dividend = frd_mag(num_q);
        div_divisor  = frd_mag(b_q);
      end
      ST_DIVD: begin
        div_start    = 1'b1;
        div_dividend = frd_mag(den_q);
        div_divisor  = frd_mag(b_q);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Data path and result updates
  always_comb begin
    num_d  = num_q;
    den_d  = den_q;
    a_d    = a_q;
    b_d    = b_q;
    qn_d   = qn_q;
    ovf_d  = ovf_q;
    res_d  = res_q;
    done_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          num_d = in_i.num_in;
          den_d = in_i.den_in;
          a_d   = in_i.num_in;
          b_d   = in_i.den_in;
          if (in_i.den_in == '0) begin
            res_d  = '{num_out: '0, den_out: '0, status: STAT_ZERO_DEN};
            done_d = 1'b1;
          end
        end
      end
      ST_REM: begin
        // truncating remainder keeps the sign of the dividend b
        if (div_done) begin
          b_d = a_q;
          a_d = b_q[DataWidth-1] ? frd_neg(div_rem) : div_rem;
        end
      end
      ST_WAITN: begin
        if (div_done) begin
          qn_d  = q_signed;
          ovf_d = q_ovf;
        end
      end
      ST_WAITD: begin
        if (div_done) begin
          done_d = 1'b1;
          if (ovf_q || q_ovf) begin
            res_d = '{num_out: '0, den_out: '0, status: STAT_OVERFLOW};
          end else begin
            res_d = '{num_out: qn_q, den_out: q_signed, status: STAT_OK};
          end
        end
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    a_q   <= a_d;
    b_q   <= b_d;
    qn_q  <= qn_d;
    ovf_q <= ovf_d;
    res_q <= res_d;
  end

  frd_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: sv/frd_divider.sv
// frd_divider: unsigned restoring divider, one quotient bit per cycle.
// Depends on frd_pkg (DataWidth).
// Gives quotient and remainder with a registered done_o once the last quotient bit is in.
module frd_divider
  import frd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DataWidth-1:0] dividend_i,
  input  logic [DataWidth-1:0] divisor_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] quotient_o,
  output logic [DataWidth-1:0] remainder_o
);

  localparam int CntW = $clog2(DataWidth);
  localparam logic [CntW-1:0] CntLast = CntW'(DataWidth - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DataWidth-1:0] rem_q, rem_d;
  logic [DataWidth-1:0] quo_q, quo_d;
  logic [DataWidth-1:0] dvs_q, dvs_d;
  logic [DataWidth:0]   shifted;
  logic [DataWidth:0]   diff;
  logic                 fits;

  // One restoring step: shift in the next dividend bit, trial subtract
  assign shifted = {rem_q, quo_q[DataWidth-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = ~diff[DataWidth];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DataWidth-1:0] : shifted[DataWidth-1:0];
      quo_d = {quo_q[DataWidth-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data path
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: sv/frd_checker.sv
// frd_checker: port-level assertions for fraction_reducer_euclid.
// Depends on frd_pkg; bound to the top level at the end of this file.
module frd_checker
  import frd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input frd_in_t  in_i,
  input logic     busy,
  input logic     done_o,
  input frd_out_t result_o
);

  // A beat with a nonzero denominator starts a reduction
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.den_in != '0)) |=> busy)
    else $error("busy not raised after accepted beat");

  // A zero denominator is answered at once with its status
  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (in_i.den_in == '0)) |=>
      (done_o && !busy && (result_o.status == STAT_ZERO_DEN)))
    else $error("zero denominator not answered");

  // Busy only ends with a result
  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // Error results carry zero parts
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != STAT_OK)) |->
      ((result_o.num_out == '0) && (result_o.den_out == '0)))
    else $error("error result with nonzero parts");

  // A good result never has a zero denominator
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_OK)) |-> (result_o.den_out != '0))
    else $error("ok result with zero denominator");

endmodule

bind fraction_reducer_euclid frd_checker u_frd_checker (.*);
